[rtl/salru_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salru_pkg: shared types and constants of the LRU cache tag store
// Holds the configuration register indexes, their reset values and the
// widths of the fixed-size result fields.
// ----------------------------------------------------------------------------
package salru_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_BLOCK_BITS  = 2'd1,
        CFG_WAYS_IN_USE = 2'd2
    } cfg_index_t;

    // Configuration register widths and reset values.
    localparam int SET_BITS_W    = 4;
    localparam int BLOCK_BITS_W  = 6;
    localparam int WAYS_IN_USE_W = 4;
    localparam int CFG_DATA_W    = 6;

    localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = 4'd4;
    localparam logic [BLOCK_BITS_W-1:0]  BLOCK_BITS_RST  = 6'd4;
    localparam logic [WAYS_IN_USE_W-1:0] WAYS_IN_USE_RST = 4'd8;

    // Result field widths.
    localparam int ADDR_PORT_W = 64;
    localparam int SET_OUT_W   = 8;
    localparam int WAY_OUT_W   = 3;
    localparam int CNT_W       = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

    // Offset plus index shift amount: up to 63 + 15.
    localparam int SHIFT_W = 7;

    // Reset ages follow the way number modulo eight.
    localparam int RANK_RST_MASK = 7;

endpackage
`default_nettype wire

[rtl/set_assoc_lru_cache_lookup_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_top: set-associative tag store with LRU
// Looks up one address per command, fills or replaces a line on a miss and
// keeps saturating hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// Usage:
//   A word (one address) is taken at a clock edge where start is high and
//   busy is low. The block then reads the set's valid and age row, and scans
//   the tags of the set one way per cycle through a single tag compare
//   unit, stopping at the first hit. A final cycle writes the updated age
//   row back, and on a miss the tag too. The result word is shown for exactly
//   one cycle, marked by done; the receiver cannot stall it and must take it
//   then. The scan covers ways_in_use ways, clamped to one through WAYS,
//   or stops earlier on a hit. A new start can be taken in the cycle where
//   done is high; the block takes no new word before the last one is done.
//   Configuration is written through cfg_valid/cfg_ready with cfg_index and
//   cfg_data; the user must write it only while no lookup is in flight, as
//   the block itself does not enforce this. cfg_ready is always high.
//   After reset the block clears the valid bits and resets the ages of
//   every set, one set per cycle, with busy high. Totals and configuration
//   registers return to their reset values at once.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup_top #(
    parameter int MAX_SET_BITS = 8,
    parameter int WAYS         = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Command channel
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [salru_pkg::ADDR_PORT_W-1:0]      address,
    // Configuration channel
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [1:0]                             cfg_index,
    input  wire logic [salru_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Result channel
    output logic                                        done,
    output logic                                        hit,
    output logic                                        evicted,
    output logic      [salru_pkg::SET_OUT_W-1:0]        set_index,
    output logic      [salru_pkg::WAY_OUT_W-1:0]        way_used,
    output logic      [salru_pkg::ADDR_PORT_W-1:0]      victim_tag,
    output logic      [salru_pkg::CNT_W-1:0]            hit_total,
    output logic      [salru_pkg::CNT_W-1:0]            miss_total,
    output logic      [salru_pkg::CNT_W-1:0]            eviction_total
);

    localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W    = WAY_W;
    localparam int NW_W      = $clog2(WAYS + 1);
    localparam int META_W    = WAYS + WAYS * RANK_W;
    localparam int TAG_W     = ADDR_WIDTH;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_UPDATE
    } state_t;

    // Sequencer and lookup registers.
    state_t                 state_reg;
    logic [SET_IDX_W-1:0]   clr_cnt_reg;
    logic [SET_IDX_W-1:0]   set_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic [WAY_W-1:0]       way_cnt_reg;
    logic                   hit_reg;
    logic [WAY_W-1:0]       way_reg;
    logic                   inv_found_reg;
    logic [WAY_W-1:0]       inv_way_reg;
    logic [RANK_W-1:0]      best_rank_reg;
    logic [WAY_W-1:0]       best_way_reg;
    logic [TAG_W-1:0]       victim_reg;

    // Configuration registers.
    logic [salru_pkg::SET_BITS_W-1:0]    set_bits_reg;
    logic [salru_pkg::BLOCK_BITS_W-1:0]  block_bits_reg;
    logic [salru_pkg::WAYS_IN_USE_W-1:0] ways_in_use_reg;

    // Totals and result registers.
    logic [salru_pkg::CNT_W-1:0]       hits_reg;
    logic [salru_pkg::CNT_W-1:0]       misses_reg;
    logic [salru_pkg::CNT_W-1:0]       evictions_reg;
    logic                              done_reg;
    logic                              out_hit_reg;
    logic                              out_evicted_reg;
    logic [salru_pkg::SET_OUT_W-1:0]   out_set_reg;
    logic [salru_pkg::WAY_OUT_W-1:0]   out_way_reg;
    logic [salru_pkg::ADDR_PORT_W-1:0] out_victim_reg;

    // Memory ports.
    logic                       meta_wr_en;
    logic [SET_IDX_W-1:0]       meta_wr_addr;
    logic [META_W-1:0]          meta_wr_data;
    logic                       meta_rd_en;
    logic [META_W-1:0]          meta_q;
    logic                       tag_wr_en;
    logic [SET_IDX_W+WAY_W-1:0] tag_wr_addr;
    logic                       tag_rd_en;
    logic [SET_IDX_W+WAY_W-1:0] tag_rd_addr;
    logic [TAG_W-1:0]           tag_q;

    // Combinational lookup signals.
    logic [TAG_W-1:0]                   addr_in;
    logic [salru_pkg::SET_BITS_W-1:0]   sb_eff;
    logic [salru_pkg::SHIFT_W-1:0]      tag_shift;
    logic [TAG_W-1:0]                   index_shifted;
    logic [SET_IDX_W-1:0]               set_mask;
    logic [SET_IDX_W-1:0]               set_calc;
    logic [TAG_W-1:0]                   tag_calc;
    logic [NW_W-1:0]                    nways;
    logic [WAY_W-1:0]                   nways_last;
    logic                               meta_valid [WAYS];
    logic [RANK_W-1:0]                  meta_rank  [WAYS];
    logic                               cur_valid;
    logic [RANK_W-1:0]                  cur_rank;
    logic                               tag_match;
    logic                               scan_last;
    logic [WAY_W-1:0]                   way_fin;
    logic                               evict_fin;
    logic [RANK_W-1:0]                  acc_rank;
    logic [META_W-1:0]                  upd_row;
    logic [META_W-1:0]                  clear_row;

    // Address split: offset, set index and tag.
    always_comb
    begin
        addr_in       = address[ADDR_WIDTH-1:0];
        sb_eff        = (set_bits_reg > MAX_SET_BITS)
                        ? salru_pkg::SET_BITS_W'(MAX_SET_BITS) : set_bits_reg;
        tag_shift     = salru_pkg::SHIFT_W'(sb_eff) + salru_pkg::SHIFT_W'(block_bits_reg);
        index_shifted = addr_in >> block_bits_reg;
        set_mask      = ~({SET_IDX_W{1'b1}} << sb_eff);
        set_calc      = index_shifted[SET_IDX_W-1:0] & set_mask;
        tag_calc      = addr_in >> tag_shift;
    end

    // Effective way count, clamped to one through WAYS.
    always_comb
    begin
        if (ways_in_use_reg == '0)
        begin
            nways = NW_W'(1);
        end
        else if (ways_in_use_reg > WAYS)
        begin
            nways = NW_W'(WAYS);
        end
        else
        begin
            nways = NW_W'(ways_in_use_reg);
        end
        nways_last = WAY_W'(nways - NW_W'(1));
    end

    // Unpack the valid and age row of the set.
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            meta_valid[i] = meta_q[i];
            meta_rank[i]  = meta_q[WAYS + i * RANK_W +: RANK_W];
        end
    end

    // Shared tag compare for the way under scan.
    always_comb
    begin
        cur_valid = meta_valid[way_cnt_reg];
        cur_rank  = meta_rank[way_cnt_reg];
        tag_match = cur_valid && (tag_q == tag_reg);
        scan_last = (way_cnt_reg == nways_last);
    end

    // Chosen way and the aged row written back after the scan.
    always_comb
    begin
        if (hit_reg)
        begin
            way_fin = way_reg;
        end
        else if (inv_found_reg)
        begin
            way_fin = inv_way_reg;
        end
        else
        begin
            way_fin = best_way_reg;
        end
        evict_fin = !hit_reg && !inv_found_reg;
        acc_rank  = meta_rank[way_fin];
        for (int i = 0; i < WAYS; i++)
        begin
            upd_row[i] = meta_valid[i] || (WAY_W'(i) == way_fin);
            if (WAY_W'(i) == way_fin)
            begin
                upd_row[WAYS + i * RANK_W +: RANK_W] = '0;
            end
            else if ((i < nways) && (meta_rank[i] < acc_rank)
                     && (meta_rank[i] < RANK_W'(WAYS - 1)))
            begin
                upd_row[WAYS + i * RANK_W +: RANK_W] = meta_rank[i] + RANK_W'(1);
            end
            else
            begin
                upd_row[WAYS + i * RANK_W +: RANK_W] = meta_rank[i];
            end
            clear_row[i] = 1'b0;
            clear_row[WAYS + i * RANK_W +: RANK_W] = RANK_W'(i & salru_pkg::RANK_RST_MASK);
        end
    end

    // Memory port control.
    always_comb
    begin
        meta_wr_en   = (state_reg == S_CLEAR) || (state_reg == S_UPDATE);
        meta_wr_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : set_reg;
        meta_wr_data = (state_reg == S_CLEAR) ? clear_row : upd_row;
        meta_rd_en   = (state_reg == S_LOOKUP);
        tag_wr_en    = (state_reg == S_UPDATE) && !hit_reg;
        tag_wr_addr  = {set_reg, way_fin};
        tag_rd_en    = (state_reg == S_LOOKUP)
                       || ((state_reg == S_SCAN) && !tag_match && !scan_last);
        tag_rd_addr  = {set_reg, (state_reg == S_LOOKUP) ? WAY_W'(0)
                                                          : way_cnt_reg + WAY_W'(1)};
    end

    // Valid bits and ages, one row per set.
    salru_ram #(
        .WIDTH  (META_W),
        .ADDR_W (SET_IDX_W)
    ) u_meta_ram (
        .clk     (clk),
        .wr_en   (meta_wr_en),
        .wr_addr (meta_wr_addr),
        .wr_data (meta_wr_data),
        .rd_en   (meta_rd_en),
        .rd_addr (set_reg),
        .rd_data (meta_q)
    );

    // Tags, one entry per line.
    salru_ram #(
        .WIDTH  (TAG_W),
        .ADDR_W (SET_IDX_W + WAY_W)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr_en),
        .wr_addr (tag_wr_addr),
        .wr_data (tag_reg),
        .rd_en   (tag_rd_en),
        .rd_addr (tag_rd_addr),
        .rd_data (tag_q)
    );

    // Sequencer, configuration registers, totals and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            set_reg         <= '0;
            tag_reg         <= '0;
            way_cnt_reg     <= '0;
            hit_reg         <= 1'b0;
            way_reg         <= '0;
            inv_found_reg   <= 1'b0;
            inv_way_reg     <= '0;
            best_rank_reg   <= '0;
            best_way_reg    <= '0;
            victim_reg      <= '0;
            set_bits_reg    <= salru_pkg::SET_BITS_RST;
            block_bits_reg  <= salru_pkg::BLOCK_BITS_RST;
            ways_in_use_reg <= salru_pkg::WAYS_IN_USE_RST;
            hits_reg        <= '0;
            misses_reg      <= '0;
            evictions_reg   <= '0;
            done_reg        <= 1'b0;
            out_hit_reg     <= 1'b0;
            out_evicted_reg <= 1'b0;
            out_set_reg     <= '0;
            out_way_reg     <= '0;
            out_victim_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            // Configuration writes.
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    salru_pkg::CFG_SET_BITS:
                    begin
                        set_bits_reg <= cfg_data[salru_pkg::SET_BITS_W-1:0];
                    end
                    salru_pkg::CFG_BLOCK_BITS:
                    begin
                        block_bits_reg <= cfg_data[salru_pkg::BLOCK_BITS_W-1:0];
                    end
                    salru_pkg::CFG_WAYS_IN_USE:
                    begin
                        ways_in_use_reg <= cfg_data[salru_pkg::WAYS_IN_USE_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + SET_IDX_W'(1);
                    if (clr_cnt_reg == {SET_IDX_W{1'b1}})
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        set_reg       <= set_calc;
                        tag_reg       <= tag_calc;
                        way_cnt_reg   <= '0;
                        hit_reg       <= 1'b0;
                        inv_found_reg <= 1'b0;
                        state_reg     <= S_LOOKUP;
                    end
                end
                S_LOOKUP:
                begin
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (tag_match)
                    begin
                        hit_reg   <= 1'b1;
                        way_reg   <= way_cnt_reg;
                        state_reg <= S_UPDATE;
                    end
                    else
                    begin
                        // Track the first empty way and the oldest way.
                        if (!cur_valid && !inv_found_reg)
                        begin
                            inv_found_reg <= 1'b1;
                            inv_way_reg   <= way_cnt_reg;
                        end
                        if ((way_cnt_reg == '0) || (cur_rank > best_rank_reg))
                        begin
                            best_rank_reg <= cur_rank;
                            best_way_reg  <= way_cnt_reg;
                            victim_reg    <= tag_q;
                        end
                        if (scan_last)
                        begin
                            state_reg <= S_UPDATE;
                        end
                        else
                        begin
                            way_cnt_reg <= way_cnt_reg + WAY_W'(1);
                        end
                    end
                end
                S_UPDATE:
                begin
                    if (hit_reg)
                    begin
                        if (hits_reg != salru_pkg::CNT_MAX)
                        begin
                            hits_reg <= hits_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (misses_reg != salru_pkg::CNT_MAX)
                        begin
                            misses_reg <= misses_reg + 1'b1;
                        end
                        if (evict_fin && (evictions_reg != salru_pkg::CNT_MAX))
                        begin
                            evictions_reg <= evictions_reg + 1'b1;
                        end
                    end
                    done_reg        <= 1'b1;
                    out_hit_reg     <= hit_reg;
                    out_evicted_reg <= evict_fin;
                    out_set_reg     <= salru_pkg::SET_OUT_W'(set_reg);
                    out_way_reg     <= salru_pkg::WAY_OUT_W'(way_fin);
                    out_victim_reg  <= evict_fin ? salru_pkg::ADDR_PORT_W'(victim_reg) : '0;
                    state_reg       <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Port drive.
    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign hit            = out_hit_reg;
    assign evicted        = out_evicted_reg;
    assign set_index      = out_set_reg;
    assign way_used       = out_way_reg;
    assign victim_tag     = out_victim_reg;
    assign hit_total      = hits_reg;
    assign miss_total     = misses_reg;
    assign eviction_total = evictions_reg;

    // A result word only follows the write-back cycle.
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_UPDATE))
        else $error("done without a write-back cycle");

    // A hit word carries a hit total one above the previous one, unless saturated.
    a_hit_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit && ($past(hits_reg) != salru_pkg::CNT_MAX))
        |-> (hit_total == $past(hits_reg) + 1'b1))
        else $error("hit total did not advance on a hit");

    // The block only becomes ready after a result or at the end of clearing.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (done || $past(state_reg == S_CLEAR)))
        else $error("busy fell without a result or end of clearing");

    // An eviction is never reported on a hit.
    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> (!hit && (miss_total != '0) && (eviction_total != '0)))
        else $error("eviction reported on a hit");

endmodule
`default_nettype wire

[rtl/salru_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salru_ram: generic simple dual-port RAM
// One write port and one read port with registered read data. The read
// data holds its value in cycles without a read.
// ----------------------------------------------------------------------------
module salru_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [2**ADDR_W];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire
